// ===== rtl/rs485_frame_deframer_assert.svh =====
// Assertion macros for the deframer, clocked on clk and held off while rst_n is low.
`ifndef RS485_FRAME_DEFRAMER_ASSERT_SVH
`define RS485_FRAME_DEFRAMER_ASSERT_SVH

`define DFR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define DFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rs485_dfr_pkg.sv =====
package rs485_dfr_pkg;

    localparam int MAX_DATA_DEFAULT = 16;

    localparam logic [7:0] SYNC_A = 8'hF3;
    localparam logic [7:0] SYNC_B = 8'hF5;
    localparam logic [7:0] TAIL_A = 8'hF3;
    localparam logic [7:0] TAIL_B = 8'hFB;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CSUM_ERR = 2'd1,
        ST_TAIL_ERR = 2'd2,
        ST_LEN_ERR  = 2'd3
    } frame_status_t;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_LEN,
        PH_DATA,
        PH_CSUM,
        PH_TAIL1,
        PH_TAIL2,
        PH_DRAIN
    } parse_state_t;

    typedef struct packed {
        logic          capture_len;
        logic          capture_data;
        logic          capture_csum;
        logic          capture_tail;
        logic          clear_idx;
        logic          drain_adv;
        logic          emit;
        logic          emit_data;
        logic          emit_len_byte;
        logic          emit_last;
        frame_status_t emit_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic sync_a;
        logic sync_b;
        logic byte_zero;
        logic len_too_big;
        logic count_done;
        logic last_drain;
        logic tail_ok;
        logic sum_ok;
        logic len_zero;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/rs485_dfr_dp.sv =====
module rs485_dfr_dp
    import rs485_dfr_pkg::*;
#(
    parameter int MAX_DATA = MAX_DATA_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    rx_byte,
    input  ctl_cmd_t      cmd,
    output dp_stat_t      stat,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [7:0]    payload_byte,
    output logic [7:0]    frame_length,
    output frame_status_t status,
    output logic          last
);

    localparam int CW = $clog2(MAX_DATA + 1);
    localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

    logic [7:0]    len_reg, len_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    csum_reg, csum_next;
    logic [7:0]    tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg;
    logic [7:0]    out_len_reg;
    frame_status_t out_status_reg;
    logic          out_last_reg;
    logic [8:0]    cnt_inc;
    logic [AW-1:0] addr;
    logic [7:0]    store [MAX_DATA];

    assign cnt_inc = 9'(cnt_reg) + 9'd1;
    assign addr    = AW'(cnt_reg);

    always_comb
    begin
        len_next  = cmd.capture_len  ? rx_byte : len_reg;
        csum_next = cmd.capture_csum ? rx_byte : csum_reg;
        tail_next = cmd.capture_tail ? rx_byte : tail_reg;
        sum_next  = sum_reg;
        if (cmd.capture_len)
        begin
            sum_next = rx_byte;
        end
        else if (cmd.capture_data)
        begin
            sum_next = sum_reg + rx_byte;
        end
        cnt_next = cnt_reg;
        if (cmd.capture_len || cmd.clear_idx)
        begin
            cnt_next = '0;
        end
        else if (cmd.capture_data || cmd.drain_adv)
        begin
            cnt_next = CW'(cnt_inc);
        end
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            sum_reg       <= '0;
            csum_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            csum_reg      <= csum_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_len_reg    <= cmd.emit_len_byte ? rx_byte : len_reg;
            out_status_reg <= cmd.emit_status;
            out_last_reg   <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_data)
        begin
            store[addr] <= rx_byte;
        end
        if (cmd.emit)
        begin
            out_data_reg <= cmd.emit_data ? store[addr] : 8'd0;
        end
    end

    always_comb
    begin
        stat.sync_a      = (rx_byte == SYNC_A);
        stat.sync_b      = (rx_byte == SYNC_B);
        stat.byte_zero   = (rx_byte == 8'd0);
        stat.len_too_big = (rx_byte > 8'(MAX_DATA));
        stat.count_done  = (cnt_inc >= {1'b0, len_reg});
        stat.last_drain  = (cnt_inc == {1'b0, len_reg});
        stat.tail_ok     = (tail_reg == TAIL_A) && (rx_byte == TAIL_B);
        stat.sum_ok      = (sum_reg == csum_reg);
        stat.len_zero    = (len_reg == 8'd0);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = out_data_reg;
    assign frame_length = out_len_reg;
    assign status       = out_status_reg;
    assign last         = out_last_reg;

endmodule

// ===== rtl/rs485_dfr_ctrl.sv =====
module rs485_dfr_ctrl
    import rs485_dfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    parse_state_t state_reg, state_next;
    logic         acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_HUNT1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        case (state_reg)
            PH_LEN, PH_TAIL2: in_ready = stat.out_free;
            PH_DRAIN:         in_ready = 1'b0;
            default:          in_ready = 1'b1;
        endcase
        acc        = in_valid && in_ready;
        state_next = state_reg;
        cmd        = '0;
        cmd.emit_status = ST_OK;
        cmd.emit_last   = 1'b1;
        case (state_reg)
            PH_HUNT1:
            begin
                if (acc)
                begin
                    state_next = stat.sync_a ? PH_HUNT2 : PH_HUNT1;
                end
            end
            PH_HUNT2:
            begin
                if (acc)
                begin
                    if (stat.sync_b)
                    begin
                        state_next = PH_LEN;
                    end
                    else if (stat.sync_a)
                    begin
                        state_next = PH_HUNT2;
                    end
                    else
                    begin
                        state_next = PH_HUNT1;
                    end
                end
            end
            PH_LEN:
            begin
                if (acc)
                begin
                    cmd.capture_len = 1'b1;
                    if (stat.len_too_big)
                    begin
                        cmd.emit          = 1'b1;
                        cmd.emit_len_byte = 1'b1;
                        cmd.emit_status   = ST_LEN_ERR;
                        state_next        = PH_HUNT1;
                    end
                    else if (stat.byte_zero)
                    begin
                        state_next = PH_CSUM;
                    end
                    else
                    begin
                        state_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (acc)
                begin
                    cmd.capture_data = 1'b1;
                    if (stat.count_done)
                    begin
                        state_next = PH_CSUM;
                    end
                end
            end
            PH_CSUM:
            begin
                if (acc)
                begin
                    cmd.capture_csum = 1'b1;
                    state_next       = PH_TAIL1;
                end
            end
            PH_TAIL1:
            begin
                if (acc)
                begin
                    cmd.capture_tail = 1'b1;
                    state_next       = PH_TAIL2;
                end
            end
            PH_TAIL2:
            begin
                if (acc)
                begin
                    state_next = PH_HUNT1;
                    if (!stat.tail_ok)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_TAIL_ERR;
                    end
                    else if (!stat.sum_ok)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_CSUM_ERR;
                    end
                    else if (stat.len_zero)
                    begin
                        cmd.emit = 1'b1;
                    end
                    else
                    begin
                        cmd.clear_idx = 1'b1;
                        state_next    = PH_DRAIN;
                    end
                end
            end
            PH_DRAIN:
            begin
                // advance one stored byte per free output slot
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_data = 1'b1;
                    cmd.emit_last = stat.last_drain;
                    cmd.drain_adv = 1'b1;
                    if (stat.last_drain)
                    begin
                        state_next = PH_HUNT1;
                    end
                end
            end
            default:
            begin
                state_next = PH_HUNT1;
            end
        endcase
    end

endmodule

// ===== rtl/rs485_frame_deframer.sv =====
// Output: a length error shows in the cycle after the length byte is taken, a bad or
// empty frame in the cycle after the second tail byte; a good frame passes the drain
// state and the output register, its N results at one per cycle while m_tready is high.
// Throughput: one byte per cycle while parsing and the output is free; none during a drain.
// Reset: rst_n clears the parser to sync hunting and empties the output register.
`include "rs485_frame_deframer_assert.svh"

module rs485_frame_deframer
    import rs485_dfr_pkg::*;
#(
    parameter int MAX_DATA = MAX_DATA_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [15:8] frame_length
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    ctl_cmd_t      cmd;
    dp_stat_t      stat;
    logic [7:0]    payload_byte;
    logic [7:0]    frame_length;
    frame_status_t status;

    rs485_dfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rs485_dfr_dp #(
        .MAX_DATA (MAX_DATA)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (s_tdata),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .payload_byte (payload_byte),
        .frame_length (frame_length),
        .status       (status),
        .last         (m_tlast)
    );

    assign m_tdata = {frame_length, payload_byte};
    assign m_tuser = status;

    `DFR_ASSERT_SAME(a_err_is_last, m_tvalid && (m_tuser != ST_OK), m_tlast, "error result not last")
    `DFR_ASSERT_SAME(a_err_zero_data, m_tvalid && (m_tuser != ST_OK), m_tdata[7:0] == 8'd0, "error result carries data")
    `DFR_ASSERT_NEXT(a_drain_blocks_input, cmd.emit && cmd.emit_data && !cmd.emit_last, !s_tready, "input taken mid drain")

endmodule
